// File: rtl/prb_pkg.sv
// prb_pkg: shared types and codes of the packet ring buffer.
// Used by packet_ring_buffer; depends on nothing.
package prb_pkg;

  // ring size is fixed by the 12-bit offset and free-space ports
  localparam int BUFFER_BYTES = 4096;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_HW,
    S_HEAD,
    S_HT,
    S_ST,
    S_L1,
    S_L2,
    S_RB,
    S_LM,
    S_DONE
  } state_t;

  localparam logic [2:0] CMD_BEGIN   = 3'd0;
  localparam logic [2:0] CMD_WBYTE   = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_FREE    = 3'd3;
  localparam logic [2:0] CMD_DISCARD = 3'd4;
  localparam logic [2:0] CMD_TICK    = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REJECT   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_DISABLED = 3'd3;
  localparam logic [2:0] ST_BADIDX   = 3'd4;

  localparam logic [7:0] PAD_TYPE = 8'hFF;

endpackage

// File: rtl/packet_ring_buffer.sv
// packet_ring_buffer: byte ring of variable length records in one synchronous RAM.
// Depends on prb_pkg.
// Transactions pass from acceptance through the state machine to the output register:
// begin_write writes the header bytes (a padding header first when the record would
// wrap); read/free/discard visit records one at a time, discard also reading the
// timestamp; a read fetches the chosen data byte.
// One transaction at a time; a new one is taken while the last result waits.
// Reset (rst, synchronous): disabled, offsets and clock zero, low mark at ring size,
// ring contents undefined.
module packet_ring_buffer #(
  parameter int HEADER_BYTES    = 8,
  parameter int WATERMARK_SLACK = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic        write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  pkt_type,
  input  logic [11:0] pkt_length,
  input  logic [7:0]  data_byte,
  input  logic [11:0] byte_index,
  input  logic [31:0] age_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  head_type,
  output logic [11:0] head_length,
  output logic [7:0]  read_byte,
  output logic [11:0] free_bytes,
  output logic [12:0] low_water
);

  localparam int BUFFER_BYTES = prb_pkg::BUFFER_BYTES;
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int LW = $clog2(BUFFER_BYTES + 1);
  localparam int HK = $clog2(HEADER_BYTES);
  localparam int SW = 20;
  localparam logic [SW-1:0] BSZ  = SW'(BUFFER_BYTES);
  localparam logic [SW-1:0] HSZ  = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] SLK  = SW'(WATERMARK_SLACK);

  prb_pkg::state_t state, state_next;

  logic [2:0]  cmd_r;
  logic [7:0]  type_r, data_r;
  logic [11:0] len_r, idx_r;
  logic [31:0] limit_r;

  logic          enabled;
  logic [AW-1:0] read_offset, write_offset;
  logic [11:0]   fill_position, pending_length;
  logic          writing;
  logic [31:0]   now_ms;
  logic [LW-1:0] low_mark;

  logic [AW-1:0] hdr_at;
  logic [7:0]    hdr_type;
  logic [15:0]   hdr_len;
  logic [HK-1:0] hdr_k;
  logic          hdr_pad;
  logic [1:0]    st_k;
  logic [23:0]   stamp;
  logic [7:0]    hd_type, len_lo;
  logic [2:0]    res_status;
  logic [7:0]    res_type, res_byte;
  logic [11:0]   res_len;

  logic [7:0]    ring [BUFFER_BYTES];
  logic [7:0]    rdata;
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  // combinational helpers
  logic [SW-1:0] free_w, room, need, commit_n, drop_n, head_len_w;
  logic          pad_needed, begin_ok, last_hdr, commit, disc_keep;
  logic [31:0]   age;
  logic [7:0]    hdr_byte;

  always_comb begin
    if (!enabled) free_w = '0;
    else if (read_offset <= write_offset)
      free_w = BSZ - SW'(1) - SW'(write_offset) + SW'(read_offset);
    else free_w = SW'(read_offset) - SW'(write_offset) - SW'(1);
    room       = BSZ - SW'(write_offset);
    pad_needed = (SW'(len_r) + (HSZ << 1)) > room;
    need       = SW'(len_r) + HSZ + (pad_needed ? room : '0);
    begin_ok   = (len_r != 12'd0) && (need <= free_w);
    commit_n   = SW'(write_offset) + HSZ + SW'(pending_length);
    commit     = writing && ((fill_position + 12'd1) >= pending_length);
    head_len_w = SW'({rdata, len_lo});
    drop_n     = SW'(read_offset) + head_len_w + HSZ;
    last_hdr   = (hdr_k == HK'(HEADER_BYTES - 1));
    age        = now_ms - {rdata, stamp};
    disc_keep  = age <= limit_r;
    hdr_byte   = 8'd0;
    if (hdr_k == HK'(0)) hdr_byte = hdr_type;
    else if (hdr_k == HK'(1)) hdr_byte = hdr_len[7:0];
    else if (hdr_k == HK'(2)) hdr_byte = hdr_len[15:8];
    else if (hdr_k == HK'(4)) hdr_byte = now_ms[7:0];
    else if (hdr_k == HK'(5)) hdr_byte = now_ms[15:8];
    else if (hdr_k == HK'(6)) hdr_byte = now_ms[23:16];
    else if (hdr_k == HK'(7)) hdr_byte = now_ms[31:24];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      prb_pkg::S_IDLE: if (in_valid) state_next = prb_pkg::S_EXEC;
      prb_pkg::S_EXEC: begin
        if (cmd_r == prb_pkg::CMD_TICK || cmd_r > prb_pkg::CMD_TICK || !enabled)
          state_next = prb_pkg::S_DONE;
        else case (cmd_r)
          prb_pkg::CMD_BEGIN: state_next = begin_ok ? prb_pkg::S_HW : prb_pkg::S_DONE;
          prb_pkg::CMD_WBYTE: state_next = commit ? prb_pkg::S_LM : prb_pkg::S_DONE;
          default:            state_next = prb_pkg::S_HEAD;
        endcase
      end
      prb_pkg::S_HW: if (last_hdr && !hdr_pad) state_next = prb_pkg::S_DONE;
      prb_pkg::S_HEAD:
        state_next = (read_offset == write_offset) ? prb_pkg::S_DONE : prb_pkg::S_HT;
      prb_pkg::S_HT: begin
        if (cmd_r == prb_pkg::CMD_DISCARD && rdata != prb_pkg::PAD_TYPE)
          state_next = (rdata != type_r) ? prb_pkg::S_DONE : prb_pkg::S_ST;
        else state_next = prb_pkg::S_L1;
      end
      prb_pkg::S_ST:
        if (st_k == 2'd3) state_next = disc_keep ? prb_pkg::S_DONE : prb_pkg::S_L1;
      prb_pkg::S_L1: state_next = prb_pkg::S_L2;
      prb_pkg::S_L2: begin
        if (cmd_r == prb_pkg::CMD_READ && hd_type != prb_pkg::PAD_TYPE)
          state_next = (SW'(idx_r) >= head_len_w) ? prb_pkg::S_DONE : prb_pkg::S_RB;
        else if (cmd_r == prb_pkg::CMD_FREE) state_next = prb_pkg::S_DONE;
        else state_next = prb_pkg::S_HEAD;
      end
      prb_pkg::S_RB: state_next = prb_pkg::S_DONE;
      prb_pkg::S_LM: state_next = prb_pkg::S_DONE;
      prb_pkg::S_DONE: if (!out_valid || out_ready) state_next = prb_pkg::S_IDLE;
      default: state_next = prb_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    waddr  = hdr_at + AW'(hdr_k);
    wdata  = hdr_byte;
    raddr  = read_offset;
    case (state)
      prb_pkg::S_HW: mem_we = 1'b1;
      prb_pkg::S_EXEC: begin
        if (cmd_r == prb_pkg::CMD_WBYTE && enabled && writing) begin
          mem_we = 1'b1;
          waddr  = AW'(SW'(write_offset) + HSZ + SW'(fill_position));
          wdata  = data_r;
        end
      end
      prb_pkg::S_HT:
        if (cmd_r == prb_pkg::CMD_DISCARD && rdata != prb_pkg::PAD_TYPE)
          raddr = read_offset + AW'(4);
        else raddr = read_offset + AW'(1);
      prb_pkg::S_ST:
        raddr = (st_k == 2'd3) ? read_offset + AW'(1) : read_offset + AW'(5) + AW'(st_k);
      prb_pkg::S_L1: raddr = read_offset + AW'(2);
      prb_pkg::S_L2: raddr = AW'(SW'(read_offset) + HSZ + SW'(idx_r));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring[waddr] <= wdata;
    rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= prb_pkg::S_IDLE;
      enabled        <= 1'b0;
      read_offset    <= '0;
      write_offset   <= '0;
      fill_position  <= '0;
      pending_length <= '0;
      writing        <= 1'b0;
      now_ms         <= '0;
      low_mark       <= LW'(BUFFER_BYTES);
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != prb_pkg::S_DONE) out_valid <= 1'b0;
      case (state)
        prb_pkg::S_IDLE: if (in_valid) begin
          cmd_r <= cmd; type_r <= pkt_type; len_r <= pkt_length;
          data_r <= data_byte; idx_r <= byte_index; limit_r <= age_limit;
          res_status <= prb_pkg::ST_OK;
          res_type <= '0; res_len <= '0; res_byte <= '0;
        end
        prb_pkg::S_EXEC: begin
          if (cmd_r == prb_pkg::CMD_TICK) now_ms <= now_ms + 32'd1;
          else if (cmd_r > prb_pkg::CMD_TICK) res_status <= prb_pkg::ST_REJECT;
          else if (!enabled) res_status <= prb_pkg::ST_DISABLED;
          else if (cmd_r == prb_pkg::CMD_BEGIN) begin
            writing <= 1'b0; fill_position <= '0; pending_length <= '0;
            hdr_k <= '0;
            if (!begin_ok) res_status <= prb_pkg::ST_REJECT;
            else begin
              hdr_at  <= write_offset;
              hdr_pad <= pad_needed;
              hdr_type <= pad_needed ? prb_pkg::PAD_TYPE : type_r;
              hdr_len  <= pad_needed ? 16'(room - HSZ) : 16'(len_r);
            end
          end else if (cmd_r == prb_pkg::CMD_WBYTE) begin
            if (!writing) res_status <= prb_pkg::ST_REJECT;
            else if (commit) begin
              write_offset   <= (commit_n >= BSZ) ? '0 : AW'(commit_n);
              writing        <= 1'b0;
              fill_position  <= '0;
              pending_length <= '0;
            end else fill_position <= fill_position + 12'd1;
          end
        end
        prb_pkg::S_HW: begin
          if (last_hdr) begin
            hdr_k <= '0;
            if (hdr_pad) begin
              // padding done: real record starts at offset zero
              write_offset <= '0;
              hdr_at   <= '0;
              hdr_pad  <= 1'b0;
              hdr_type <= type_r;
              hdr_len  <= 16'(len_r);
            end else begin
              pending_length <= len_r;
              writing        <= 1'b1;
            end
          end else hdr_k <= hdr_k + HK'(1);
        end
        prb_pkg::S_HEAD:
          if (read_offset == write_offset && cmd_r != prb_pkg::CMD_DISCARD)
            res_status <= prb_pkg::ST_EMPTY;
        prb_pkg::S_HT: begin
          hd_type <= rdata;
          st_k    <= '0;
        end
        prb_pkg::S_ST: begin
          st_k  <= st_k + 2'd1;
          stamp <= {rdata, stamp[23:8]};
        end
        prb_pkg::S_L1: len_lo <= rdata;
        prb_pkg::S_L2: begin
          if (cmd_r == prb_pkg::CMD_READ && hd_type != prb_pkg::PAD_TYPE) begin
            res_type <= hd_type;
            res_len  <= head_len_w[11:0];
            if (SW'(idx_r) >= head_len_w) res_status <= prb_pkg::ST_BADIDX;
          end else
            read_offset <= (drop_n >= BSZ) ? '0 : AW'(drop_n);
        end
        prb_pkg::S_RB: res_byte <= rdata;
        prb_pkg::S_LM:
          if (SW'(low_mark) > free_w + SLK) low_mark <= LW'(free_w);
        prb_pkg::S_DONE: if (!out_valid || out_ready) begin
          out_valid   <= 1'b1;
          status      <= res_status;
          head_type   <= res_type;
          head_length <= res_len;
          read_byte   <= res_byte;
          free_bytes  <= free_w[11:0];
          low_water   <= 13'(SW'(low_mark));
        end
        default: ;
      endcase
      if (write_enable) begin
        enabled        <= write_data;
        read_offset    <= '0;
        write_offset   <= '0;
        fill_position  <= '0;
        pending_length <= '0;
        writing        <= 1'b0;
        if (write_data) low_mark <= LW'(BUFFER_BYTES);
      end
    end
  end

  assign in_ready = (state == prb_pkg::S_IDLE);

  a_fill_below_len: assert property (@(posedge clk) disable iff (rst)
    writing |-> (fill_position < pending_length))
    else $error("fill position reached record length while writing");
  a_offsets_in_ring: assert property (@(posedge clk) disable iff (rst)
    (SW'(read_offset) < BSZ) && (SW'(write_offset) < BSZ))
    else $error("ring offset out of range");
  a_disabled_idle: assert property (@(posedge clk) disable iff (rst)
    !enabled |-> !writing)
    else $error("record pending while disabled");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(free_bytes)))
    else $error("result dropped under stall");

endmodule

// File: tb/sv/packet_ring_buffer_test.sv
// packet_ring_buffer_test: self-checking testbench for the packet ring buffer.
// Depends on prb_pkg and packet_ring_buffer; it predicts every result from its own
// model of the ring and compares each result, all output fields at once.
module packet_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_BYTES = 4096;
  localparam int HDR_BYTES = 8;
  localparam int SLACK = 1000;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  ptype;
    logic [11:0] plen;
    logic [7:0]  dbyte;
    logic [11:0] bidx;
    logic [31:0] age;
  } ring_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  htype;
    logic [11:0] hlen;
    logic [7:0]  rbyte;
    logic [11:0] free;
    logic [12:0] lowm;
  } ring_resp_t;

  logic clk = 0, rst = 1;
  logic write_enable = 0, write_data = 0;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  logic [2:0] cmd = '0;
  logic [7:0] pkt_type = '0, data_byte = '0;
  logic [11:0] pkt_length = '0, byte_index = '0;
  logic [31:0] age_limit = '0;
  logic [2:0] status;
  logic [7:0] head_type, read_byte;
  logic [11:0] head_length, free_bytes;
  logic [12:0] low_water;

  packet_ring_buffer uut (
    .clk(clk), .rst(rst), .write_enable(write_enable), .write_data(write_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .pkt_type(pkt_type),
    .pkt_length(pkt_length), .data_byte(data_byte), .byte_index(byte_index),
    .age_limit(age_limit), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .head_type(head_type), .head_length(head_length),
    .read_byte(read_byte), .free_bytes(free_bytes), .low_water(low_water)
  );

  ring_cmd_t  cmd_q[$];
  ring_resp_t resp_q[$];
  ring_cmd_t  cur;
  int gap_left = 0, stall_left = 0;
  int cmds_sent = 0, resps_seen = 0, mismatches = 0, cycles = 0;
  bit calm = 0;

  // ring model
  bit [7:0] ring_img [0:RING_BYTES-1];
  bit ring_on = 0, rec_open = 0;
  int unsigned rd_off = 0, wr_off = 0, fill_pos = 0, open_len = 0, now_ms = 0;
  int unsigned low_mark = RING_BYTES;

  function automatic int unsigned room_now();
    if (!ring_on) return 0;
    if (rd_off <= wr_off) return RING_BYTES - 1 - wr_off + rd_off;
    return rd_off - wr_off - 1;
  endfunction

  function automatic void put_hdr(int unsigned at, int unsigned typ, int unsigned len);
    for (int k = 0; k < HDR_BYTES; k++) ring_img[(at + k) % RING_BYTES] = 8'd0;
    ring_img[at % RING_BYTES] = 8'(typ);
    ring_img[(at + 1) % RING_BYTES] = 8'(len);
    ring_img[(at + 2) % RING_BYTES] = 8'(len >> 8);
    ring_img[(at + 4) % RING_BYTES] = 8'(now_ms);
    ring_img[(at + 5) % RING_BYTES] = 8'(now_ms >> 8);
    ring_img[(at + 6) % RING_BYTES] = 8'(now_ms >> 16);
    ring_img[(at + 7) % RING_BYTES] = 8'(now_ms >> 24);
  endfunction

  function automatic int unsigned head_len();
    int unsigned lo, hi;
    lo = ring_img[(rd_off + 1) % RING_BYTES];
    hi = ring_img[(rd_off + 2) % RING_BYTES];
    return lo | (hi << 8);
  endfunction

  function automatic int unsigned head_stamp();
    int unsigned s = 0;
    for (int k = 3; k >= 0; k--) s = (s << 8) | ring_img[(rd_off + 4 + k) % RING_BYTES];
    return s;
  endfunction

  function automatic void drop_head();
    int unsigned n = rd_off + head_len() + HDR_BYTES;
    rd_off = (n >= RING_BYTES) ? 0 : n;
  endfunction

  function automatic void apply_enable(bit v);
    ring_on = v;
    rd_off = 0; wr_off = 0; fill_pos = 0; open_len = 0; rec_open = 0;
    if (v) low_mark = RING_BYTES;
  endfunction

  function automatic ring_resp_t ring_step(ring_cmd_t c);
    ring_resp_t r;
    int unsigned room, need, n, t;
    r = '0;
    r.status = prb_pkg::ST_OK;
    if (c.cmd == prb_pkg::CMD_TICK) begin
      now_ms = now_ms + 1;
    end else if (c.cmd > prb_pkg::CMD_TICK) begin
      r.status = prb_pkg::ST_REJECT;
    end else if (!ring_on) begin
      r.status = prb_pkg::ST_DISABLED;
    end else if (c.cmd == prb_pkg::CMD_BEGIN) begin
      rec_open = 0; fill_pos = 0; open_len = 0;
      room = RING_BYTES - wr_off;
      need = c.plen + HDR_BYTES;
      if (c.plen + 2 * HDR_BYTES > room) need += room;
      if (c.plen == 0 || need > room_now()) begin
        r.status = prb_pkg::ST_REJECT;
      end else begin
        if (c.plen + 2 * HDR_BYTES > room) begin
          put_hdr(wr_off, prb_pkg::PAD_TYPE, room - HDR_BYTES);
          wr_off = 0;
        end
        put_hdr(wr_off, c.ptype, c.plen);
        open_len = c.plen;
        rec_open = 1;
      end
    end else if (c.cmd == prb_pkg::CMD_WBYTE) begin
      if (!rec_open) begin
        r.status = prb_pkg::ST_REJECT;
      end else begin
        ring_img[(wr_off + HDR_BYTES + fill_pos) % RING_BYTES] = c.dbyte;
        fill_pos++;
        if (fill_pos >= open_len) begin
          n = wr_off + HDR_BYTES + open_len;
          wr_off = (n >= RING_BYTES) ? 0 : n;
          rec_open = 0; fill_pos = 0; open_len = 0;
          if (low_mark > room_now() + SLACK) low_mark = room_now();
        end
      end
    end else if (c.cmd == prb_pkg::CMD_READ) begin
      for (int g = 0; g < RING_BYTES && rd_off != wr_off &&
                      ring_img[rd_off] == prb_pkg::PAD_TYPE; g++)
        drop_head();
      if (rd_off == wr_off || ring_img[rd_off] == prb_pkg::PAD_TYPE) begin
        r.status = prb_pkg::ST_EMPTY;
      end else begin
        r.htype = ring_img[rd_off];
        r.hlen = 12'(head_len());
        if (c.bidx >= head_len()) r.status = prb_pkg::ST_BADIDX;
        else r.rbyte = ring_img[(rd_off + HDR_BYTES + c.bidx) % RING_BYTES];
      end
    end else if (c.cmd == prb_pkg::CMD_FREE) begin
      if (rd_off == wr_off) r.status = prb_pkg::ST_EMPTY;
      else drop_head();
    end else begin
      for (int g = 0; g < RING_BYTES && rd_off != wr_off; g++) begin
        t = ring_img[rd_off];
        if (t != prb_pkg::PAD_TYPE) begin
          if (t != c.ptype) break;
          if (now_ms - head_stamp() <= c.age) break;
        end
        drop_head();
      end
    end
    r.free = 12'(room_now());
    r.lowm = 13'(low_mark);
    return r;
  endfunction

  function automatic ring_cmd_t mk(logic [2:0] c, logic [7:0] ty, logic [11:0] len,
                                   logic [7:0] d, logic [11:0] idx, logic [31:0] age);
    ring_cmd_t x;
    x.cmd = c; x.ptype = ty; x.plen = len; x.dbyte = d; x.bidx = idx; x.age = age;
    return x;
  endfunction

  task automatic push_record(logic [7:0] ty, int unsigned len, int unsigned bytes);
    cmd_q.push_back(mk(prb_pkg::CMD_BEGIN, ty, 12'(len), 8'($urandom), 12'($urandom),
                       $urandom));
    for (int i = 0; i < bytes; i++)
      cmd_q.push_back(mk(prb_pkg::CMD_WBYTE, 8'($urandom), 12'($urandom),
                         8'($urandom_range(0, 255)), 12'($urandom), $urandom));
  endtask

  // mostly well-formed records with reads, frees, discards and ticks; some noise
  task automatic push_traffic(int n);
    int k, len, sel;
    logic [7:0] ty;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(0, 99);
      ty = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
      if (sel < 40) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 48);
        // occasionally cut the record short
        push_record(ty, len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len);
        k += len + 1;
      end else begin
        if (sel < 55)
          cmd_q.push_back(mk(prb_pkg::CMD_READ, 8'($urandom), 12'($urandom), 8'($urandom),
            ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 60)),
            $urandom));
        else if (sel < 68)
          cmd_q.push_back(mk(prb_pkg::CMD_FREE, 8'($urandom), 12'($urandom), 8'($urandom),
                             12'($urandom), $urandom));
        else if (sel < 76)
          cmd_q.push_back(mk(prb_pkg::CMD_DISCARD,
            ($urandom_range(0, 4) == 0) ? prb_pkg::PAD_TYPE : ty,
            12'($urandom), 8'($urandom), 12'($urandom),
            ($urandom_range(0, 2) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20))));
        else if (sel < 90)
          cmd_q.push_back(mk(prb_pkg::CMD_TICK, 8'($urandom), 12'($urandom), 8'($urandom),
                             12'($urandom), $urandom));
        else
          cmd_q.push_back(mk(3'($urandom_range(0, 7)), 8'($urandom), 12'($urandom),
                             8'($urandom), 12'($urandom), $urandom));
        k++;
      end
    end
  endtask

  // checked between edges so the sender's updates have settled
  task automatic drain();
    while (cmd_q.size() != 0 || in_valid || resp_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_enable(bit v);
    @(posedge clk);
    write_enable <= 1'b1;
    write_data <= v;
    apply_enable(v);
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resp_q.push_back(ring_step(cur));
        cmds_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0 && !calm && $urandom_range(0, 15) == 0) begin
          gap_left = $urandom_range(1, 12);
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur = cmd_q.pop_front();
          cmd <= cur.cmd; pkt_type <= cur.ptype; pkt_length <= cur.plen;
          data_byte <= cur.dbyte; byte_index <= cur.bidx; age_limit <= cur.age;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    ring_resp_t want, got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status, head_type, head_length, read_byte, free_bytes, low_water};
        resps_seen++;
        if (resp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = resp_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at result %0d: expected %p, got %p", resps_seen, want, got);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("packet_ring_buffer_test: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // disabled: each command answers disabled, except tick (ok) and undefined codes (rejected)
    for (int c = 0; c < 8; c++)
      cmd_q.push_back(mk(3'(c), 8'hFF, 12'hFFF, 8'hFF, 12'hFFF, '1));
    drain();
    set_enable(1'b1);
    cmd_q.push_back(mk(prb_pkg::CMD_READ, 8'd0, 12'd0, 8'd0, 12'd0, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_FREE, 8'd0, 12'd0, 8'd0, 12'd0, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_WBYTE, 8'd0, 12'd0, 8'hA5, 12'd0, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_BEGIN, 8'd1, 12'd0, 8'd0, 12'd0, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_BEGIN, 8'd1, 12'hFFF, 8'd0, 12'd0, 32'd0));
    push_record(8'h00, 1, 1);
    push_record(8'hFF, 2, 2);
    push_record(8'h02, 5, 2);
    push_record(8'h03, 3, 3);
    cmd_q.push_back(mk(prb_pkg::CMD_READ, 8'd0, 12'd0, 8'd0, 12'd0, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_FREE, 8'd0, 12'd0, 8'd0, 12'd0, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_READ, 8'd0, 12'd0, 8'd0, 12'd2, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_READ, 8'd0, 12'd0, 8'd0, 12'd3, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_READ, 8'd0, 12'd0, 8'd0, 12'hFFF, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_TICK, 8'd0, 12'd0, 8'd0, 12'd0, 32'd0));
    cmd_q.push_back(mk(prb_pkg::CMD_DISCARD, 8'h03, 12'd0, 8'd0, 12'd0, '1));
    cmd_q.push_back(mk(prb_pkg::CMD_DISCARD, 8'h03, 12'd0, 8'd0, 12'd0, 32'd0));
    cmd_q.push_back(mk(3'd6, 8'd0, 12'd0, 8'd0, 12'd0, 32'd0));
    cmd_q.push_back(mk(3'd7, '1, '1, '1, '1, '1));
    drain();
    push_traffic(450);
    drain();
    set_enable(1'b0);
    push_traffic(20);
    drain();
    set_enable(1'b1);
    push_traffic(450);
    drain();
    calm = 1;
    push_traffic(350);
    drain();
    $display("%0d commands sent, %0d results checked, %0d ms ticked, low water %0d",
             cmds_sent, resps_seen, now_ms, low_mark);
    if (mismatches == 0 && resp_q.size() == 0) begin
      $display("packet_ring_buffer_test: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, resp_q.size());
      $display("packet_ring_buffer_test: done, errors");
    end
    $finish;
  end
endmodule
